// ----- rtl/lvime_pkg.sv -----
// Shared types, command and opcode codes, and helpers of the lane vector integer executor.
package lvime_pkg;

	// Default sizes.
	localparam int LANE_COUNT_DEF    = 8;
	localparam int REG_COUNT_DEF     = 8;
	localparam int SCRATCH_WORDS_DEF = 2048;

	// Fixed reciprocal precision used for small constant remainders.
	localparam int RECIP_SHIFT = 24;

	// Command codes.
	localparam logic [2:0] CMD_WR_REG  = 3'd0;
	localparam logic [2:0] CMD_RD_REG  = 3'd1;
	localparam logic [2:0] CMD_WR_MEM  = 3'd2;
	localparam logic [2:0] CMD_RD_MEM  = 3'd3;
	localparam logic [2:0] CMD_EXECUTE = 3'd4;

	// Instruction opcodes.
	localparam logic [4:0] OP_IADD_RS  = 5'd0;
	localparam logic [4:0] OP_ISUB     = 5'd1;
	localparam logic [4:0] OP_IMUL     = 5'd2;
	localparam logic [4:0] OP_INEG     = 5'd3;
	localparam logic [4:0] OP_IXOR     = 5'd4;
	localparam logic [4:0] OP_IROR     = 5'd5;
	localparam logic [4:0] OP_IROL     = 5'd6;
	localparam logic [4:0] OP_ISWAP    = 5'd7;
	localparam logic [4:0] OP_IMULH    = 5'd8;
	localparam logic [4:0] OP_ISMULH   = 5'd9;
	localparam logic [4:0] OP_IADD_M   = 5'd10;
	localparam logic [4:0] OP_ISUB_M   = 5'd11;
	localparam logic [4:0] OP_IMUL_M   = 5'd12;
	localparam logic [4:0] OP_IMULH_M  = 5'd13;
	localparam logic [4:0] OP_ISMULH_M = 5'd14;
	localparam logic [4:0] OP_IXOR_M   = 5'd15;
	localparam logic [4:0] OP_ISTORE   = 5'd16;

	// Request beat.
	typedef struct packed {
		logic [2:0]         cmd;
		logic [2:0]         lane;
		logic [10:0]        index;
		logic [63:0]        data;
		logic [4:0]         op;
		logic [2:0]         dst_reg;
		logic [2:0]         src_reg;
		logic [5:0]         shift;
		logic signed [31:0] immediate;
		logic [13:0]        mem_mask;
	} in_item_t;

	// Response beat.
	typedef struct packed {
		logic [63:0] read_data;
		logic        was_read;
	} out_item_t;

	// Strobes and shared operands sent from the sequencer to every lane.
	typedef struct packed {
		logic        reg_rd;
		logic        reg_wr_host;
		logic        latch_ops;
		logic        latch_addr;
		logic        latch_word;
		logic        mem_wr_host;
		logic        mem_rd_host;
		logic        mem_rd_exec;
		logic        store_wr;
		logic        x1;
		logic        x2;
		logic        wb_dst;
		logic        wb_src;
		logic [4:0]  op;
		logic [5:0]  shift;
		logic [63:0] imm;
		logic [13:0] mask;
		logic [63:0] data;
	} lvime_ctl_t;

	// Remainder of an 11-bit value by a constant below 2048, through a
	// reciprocal multiply and one correcting subtract. The reciprocal has one
	// bit above the precision so that a divisor of one is covered.
	function automatic logic [10:0] mod_by_const(input logic [10:0] v,
		input logic [11:0] divisor, input logic [24:0] recip);
		logic [35:0] prod;
		logic [10:0] quo;
		logic [22:0] qd;
		logic [11:0] rem;
		prod = 36'(v) * 36'(recip);
		quo  = prod[34:24];
		qd   = 23'(quo) * 23'(divisor);
		rem  = 12'(v) - qd[11:0];
		if (rem >= divisor) begin
			rem = rem - divisor;
		end
		return rem[10:0];
	endfunction

endpackage

// ----- rtl/lvime_if.sv -----
// Valid/ready channel carrying one payload beat.
interface lvime_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ----- rtl/lane_vector_integer_memory_executor_top.sv -----
// Top level of the lane vector integer executor: request holding stage, sequencer, lanes, merge.
//
// Request channel req carries one command per beat; response channel rsp returns
// exactly one beat per request, in order. Commands load or read one register or
// one scratchpad word of the chosen lane, or execute one instruction on all
// lanes at once; every lane has its own registers and scratchpad.
// A request is taken into a holding register whenever that register is empty, so
// the next beat is accepted while the current one executes or waits at rsp.
// After the holding register, a load passes the issue and done states and a read adds
// the read-data state; register instructions pass operand capture, the X1 and X2 ALU
// states and write-back, and a swap of two distinct registers adds a second write-back;
// scratchpad instructions add address, word and scratchpad states before the ALU, and a
// store writes there and skips the ALU. The shared sequencer handles one command at a time.
// Reset clears the registers to zero (through written flags), empties both the
// holding and the response stage; scratchpad contents stay undefined until written.
// When rsp stalls, the finished response is held and the sequencer waits with
// the next result; the holding register still takes one more request.
module lane_vector_integer_memory_executor_top #(
	parameter int LANE_COUNT    = lvime_pkg::LANE_COUNT_DEF,
	parameter int REG_COUNT     = lvime_pkg::REG_COUNT_DEF,
	parameter int SCRATCH_WORDS = lvime_pkg::SCRATCH_WORDS_DEF
) (
	input logic clk,
	input logic arst_n,
	lvime_if.sink   req,
	lvime_if.source rsp
);
	import lvime_pkg::*;

	localparam int LW     = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
	localparam int RW     = $clog2(REG_COUNT);
	localparam int SWW    = $clog2(SCRATCH_WORDS);
	localparam bit MOD_SW = (SCRATCH_WORDS < 2048);
	localparam int SW_DIV = MOD_SW ? SCRATCH_WORDS : 2047;
	localparam int SW_RECIP   = (2**RECIP_SHIFT + SW_DIV - 1) / SW_DIV;
	localparam int REG_RECIP  = (2**RECIP_SHIFT + REG_COUNT - 1) / REG_COUNT;
	localparam int LANE_RECIP = (2**RECIP_SHIFT + LANE_COUNT - 1) / LANE_COUNT;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ISSUE = 4'd1;
	localparam logic [3:0] ST_RDATA = 4'd2;
	localparam logic [3:0] ST_OPS   = 4'd3;
	localparam logic [3:0] ST_ADDR  = 4'd4;
	localparam logic [3:0] ST_WORD  = 4'd5;
	localparam logic [3:0] ST_MEM   = 4'd6;
	localparam logic [3:0] ST_X1    = 4'd7;
	localparam logic [3:0] ST_X2    = 4'd8;
	localparam logic [3:0] ST_WB    = 4'd9;
	localparam logic [3:0] ST_WB2   = 4'd10;
	localparam logic [3:0] ST_DONE  = 4'd11;

	logic          hold_valid_q;
	in_item_t      hold_q;
	logic [3:0]    state_q;
	logic [2:0]    cmd_q;
	logic [4:0]    op_q;
	logic [5:0]    shift_q;
	logic [31:0]   imm_q;
	logic [13:0]   mask_q;
	logic [63:0]   data_q;
	logic [LW-1:0] lane_q;
	logic [RW-1:0] ridx_q, d_q, s_q;
	logic [SWW-1:0] word_q;
	logic [63:0]   res_data_q;
	logic          res_rd_q;
	logic          out_valid_q;
	out_item_t     out_q;
	logic          out_free;

	logic [10:0]    lane_red, ridx_red, d_red, s_red, word_red;
	logic [LW+10:0] lane_ext;
	logic [RW+10:0] ridx_ext, d_ext, s_ext;
	logic [SWW+10:0] word_ext;

	lvime_ctl_t     ctl;
	logic [RW-1:0]  reg_a_addr, reg_wr_addr;
	logic [LANE_COUNT-1:0] lane_sel;
	logic [63:0]    lane_reg_rd [LANE_COUNT];
	logic [63:0]    lane_mem_rd [LANE_COUNT];
	logic           is_mem_op;
	logic           swap_two;

	// Request holding register.
	assign req.ready = !hold_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (req.valid && req.ready) begin
			hold_valid_q <= 1'b1;
		end else if (state_q == ST_IDLE) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			hold_q <= req.payload;
		end
	end

	// Reduction of lane, register and word numbers to the configured sizes.
	assign lane_red = mod_by_const(11'(hold_q.lane), 12'(LANE_COUNT), 25'(LANE_RECIP));
	assign ridx_red = mod_by_const(hold_q.index, 12'(REG_COUNT), 25'(REG_RECIP));
	assign d_red    = mod_by_const(11'(hold_q.dst_reg), 12'(REG_COUNT), 25'(REG_RECIP));
	assign s_red    = mod_by_const(11'(hold_q.src_reg), 12'(REG_COUNT), 25'(REG_RECIP));
	assign word_red = MOD_SW ? mod_by_const(hold_q.index, 12'(SW_DIV), 25'(SW_RECIP))
		: hold_q.index;
	assign lane_ext = {{LW{1'b0}}, lane_red};
	assign ridx_ext = {{RW{1'b0}}, ridx_red};
	assign d_ext    = {{RW{1'b0}}, d_red};
	assign s_ext    = {{RW{1'b0}}, s_red};
	assign word_ext = {{SWW{1'b0}}, word_red};

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && hold_valid_q) begin
			cmd_q   <= hold_q.cmd;
			op_q    <= hold_q.op;
			shift_q <= hold_q.shift;
			imm_q   <= hold_q.immediate;
			mask_q  <= hold_q.mem_mask;
			data_q  <= hold_q.data;
			lane_q  <= lane_ext[LW-1:0];
			ridx_q  <= ridx_ext[RW-1:0];
			d_q     <= d_ext[RW-1:0];
			s_q     <= s_ext[RW-1:0];
			word_q  <= word_ext[SWW-1:0];
		end
	end

	assign is_mem_op = (op_q >= OP_IADD_M) && (op_q <= OP_ISTORE);
	assign swap_two  = (op_q == OP_ISWAP) && (d_q != s_q);
	assign out_free  = !out_valid_q || rsp.ready;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (hold_valid_q) begin
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					case (cmd_q)
						CMD_RD_REG, CMD_RD_MEM: state_q <= ST_RDATA;
						CMD_EXECUTE:            state_q <= ST_OPS;
						default:                state_q <= ST_DONE;
					endcase
				end
				ST_RDATA: state_q <= ST_DONE;
				ST_OPS:   state_q <= is_mem_op ? ST_ADDR : ST_X1;
				ST_ADDR:  state_q <= ST_WORD;
				ST_WORD:  state_q <= ST_MEM;
				ST_MEM:   state_q <= (op_q == OP_ISTORE) ? ST_DONE : ST_X1;
				ST_X1:    state_q <= ST_X2;
				ST_X2:    state_q <= ST_WB;
				ST_WB:    state_q <= swap_two ? ST_WB2 : ST_DONE;
				ST_WB2:   state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Lane strobes decoded from the sequencer state.
	always_comb begin
		ctl             = '0;
		ctl.op          = op_q;
		ctl.shift       = shift_q;
		ctl.imm         = {{32{imm_q[31]}}, imm_q};
		ctl.mask        = mask_q;
		ctl.data        = data_q;
		ctl.reg_rd      = (state_q == ST_ISSUE) && ((cmd_q == CMD_RD_REG)
			|| (cmd_q == CMD_EXECUTE));
		ctl.reg_wr_host = (state_q == ST_ISSUE) && (cmd_q == CMD_WR_REG);
		ctl.mem_wr_host = (state_q == ST_ISSUE) && (cmd_q == CMD_WR_MEM);
		ctl.mem_rd_host = (state_q == ST_ISSUE) && (cmd_q == CMD_RD_MEM);
		ctl.latch_ops   = (state_q == ST_OPS);
		ctl.latch_addr  = (state_q == ST_ADDR);
		ctl.latch_word  = (state_q == ST_WORD);
		ctl.mem_rd_exec = (state_q == ST_MEM) && (op_q != OP_ISTORE);
		ctl.store_wr    = (state_q == ST_MEM) && (op_q == OP_ISTORE);
		ctl.x1          = (state_q == ST_X1);
		ctl.x2          = (state_q == ST_X2);
		ctl.wb_dst      = (state_q == ST_WB);
		ctl.wb_src      = (state_q == ST_WB2);
	end

	assign reg_a_addr = (cmd_q == CMD_EXECUTE) ? d_q : ridx_q;
	always_comb begin
		case (state_q)
			ST_WB:   reg_wr_addr = d_q;
			ST_WB2:  reg_wr_addr = s_q;
			default: reg_wr_addr = ridx_q;
		endcase
	end

	// Lanes.
	for (genvar l = 0; l < LANE_COUNT; l++) begin : g_lane
		assign lane_sel[l] = (lane_q == LW'(l));

		lvime_lane #(.REG_COUNT(REG_COUNT), .SCRATCH_WORDS(SCRATCH_WORDS)) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.sel(lane_sel[l]),
			.reg_a_addr(reg_a_addr),
			.reg_b_addr(s_q),
			.reg_wr_addr(reg_wr_addr),
			.host_word(word_q),
			.reg_rd_data(lane_reg_rd[l]),
			.mem_rd_data(lane_mem_rd[l])
		);
	end

	// Merge: pick the read data of the addressed lane.
	always_ff @(posedge clk) begin
		if (state_q == ST_ISSUE) begin
			res_data_q <= 64'd0;
		end else if (state_q == ST_RDATA) begin
			res_data_q <= (cmd_q == CMD_RD_REG) ? lane_reg_rd[lane_q] : lane_mem_rd[lane_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_rd_q <= 1'b0;
		end else if (state_q == ST_ISSUE) begin
			res_rd_q <= (cmd_q == CMD_RD_REG) || (cmd_q == CMD_RD_MEM);
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q.read_data <= res_data_q;
			out_q.was_read  <= res_rd_q;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;
endmodule

// ----- rtl/lvime_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lvime_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic                                       rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

// ----- rtl/lvime_lane.sv -----
// One execution lane: register file, private scratchpad, address unit and ALU.
module lvime_lane #(
	parameter int REG_COUNT     = 8,
	parameter int SCRATCH_WORDS = 2048
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lvime_pkg::lvime_ctl_t             ctl,
	input  logic                              sel,
	input  logic [$clog2(REG_COUNT)-1:0]      reg_a_addr,
	input  logic [$clog2(REG_COUNT)-1:0]      reg_b_addr,
	input  logic [$clog2(REG_COUNT)-1:0]      reg_wr_addr,
	input  logic [$clog2(SCRATCH_WORDS)-1:0]  host_word,
	output logic [63:0]                       reg_rd_data,
	output logic [63:0]                       mem_rd_data
);
	import lvime_pkg::*;

	localparam int SWW    = $clog2(SCRATCH_WORDS);
	localparam bit MOD_SW = (SCRATCH_WORDS < 2048);
	localparam int SW_DIV = MOD_SW ? SCRATCH_WORDS : 2047;
	localparam int SW_RECIP = (2**RECIP_SHIFT + SW_DIV - 1) / SW_DIV;

	logic [REG_COUNT-1:0] reg_valid_q;
	logic                 va_q, vb_q;
	logic [63:0]          ram_a_rd, ram_b_rd, a_val, b_val;
	logic                 reg_we;
	logic [63:0]          reg_wdata;
	logic                 writes_dst;
	logic                 is_mem;
	logic [63:0]          dv_q, sv_q;
	logic [63:0]          base;
	logic [13:0]          addr_sum;
	logic [10:0]          addr_raw_q;
	logic [10:0]          word_red;
	logic [SWW+10:0]      word_ext;
	logic [SWW-1:0]       word_q;
	logic [SWW-1:0]       mem_addr;
	logic                 mem_we, mem_re;
	logic [63:0]          mem_wdata;
	logic [63:0]          opb;
	logic [127:0]         rot_r, rot_l;
	logic [63:0]          res_x1;
	logic [63:0]          res_s1, corr_s1;
	logic [63:0]          pp_ll_s1, pp_lh_s1, pp_hl_s1, pp_hh_s1;
	logic [63:0]          res_s2, corr_s2;
	logic [127:0]         prod_s2;
	logic [63:0]          res_final;

	assign writes_dst = (ctl.op <= OP_IXOR_M);
	assign is_mem     = (ctl.op >= OP_IADD_M) && (ctl.op <= OP_ISTORE);

	// Register write selection: host load, destination write-back, swap second half.
	assign reg_we = (ctl.reg_wr_host & sel) | (ctl.wb_dst & writes_dst) | ctl.wb_src;
	always_comb begin
		if (ctl.reg_wr_host) begin
			reg_wdata = ctl.data;
		end else if (ctl.wb_src) begin
			reg_wdata = dv_q;
		end else begin
			reg_wdata = res_final;
		end
	end

	// Two register file copies give two read ports.
	lvime_ram #(.WIDTH(64), .DEPTH(REG_COUNT)) u_reg_a (
		.clk(clk), .wr_en(reg_we), .wr_addr(reg_wr_addr), .wr_data(reg_wdata),
		.rd_en(ctl.reg_rd), .rd_addr(reg_a_addr), .rd_data(ram_a_rd)
	);
	lvime_ram #(.WIDTH(64), .DEPTH(REG_COUNT)) u_reg_b (
		.clk(clk), .wr_en(reg_we), .wr_addr(reg_wr_addr), .wr_data(reg_wdata),
		.rd_en(ctl.reg_rd), .rd_addr(reg_b_addr), .rd_data(ram_b_rd)
	);

	// Written flags make never-written registers read as zero after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_valid_q <= '0;
			va_q        <= 1'b0;
			vb_q        <= 1'b0;
		end else begin
			if (reg_we) begin
				reg_valid_q[reg_wr_addr] <= 1'b1;
			end
			if (ctl.reg_rd) begin
				va_q <= reg_valid_q[reg_a_addr];
				vb_q <= reg_valid_q[reg_b_addr];
			end
		end
	end

	assign a_val       = va_q ? ram_a_rd : 64'd0;
	assign b_val       = vb_q ? ram_b_rd : 64'd0;
	assign reg_rd_data = a_val;

	// Operand capture, byte address, and word index reduction.
	assign base     = (ctl.op == OP_ISTORE) ? dv_q : sv_q;
	assign addr_sum = base[13:0] + ctl.imm[13:0];
	assign word_red = MOD_SW ? mod_by_const(addr_raw_q, 12'(SW_DIV), 25'(SW_RECIP))
		: addr_raw_q;
	assign word_ext = {{SWW{1'b0}}, word_red};

	always_ff @(posedge clk) begin
		if (ctl.latch_ops) begin
			dv_q <= a_val;
			sv_q <= b_val;
		end
		if (ctl.latch_addr) begin
			addr_raw_q <= addr_sum[13:3] & ctl.mask[13:3];
		end
		if (ctl.latch_word) begin
			word_q <= word_ext[SWW-1:0];
		end
	end

	// Private scratchpad.
	assign mem_addr  = (ctl.mem_wr_host | ctl.mem_rd_host) ? host_word : word_q;
	assign mem_we    = (ctl.mem_wr_host & sel) | ctl.store_wr;
	assign mem_wdata = ctl.mem_wr_host ? ctl.data : sv_q;
	assign mem_re    = ctl.mem_rd_host | ctl.mem_rd_exec;

	lvime_ram #(.WIDTH(64), .DEPTH(SCRATCH_WORDS)) u_scratch (
		.clk(clk), .wr_en(mem_we), .wr_addr(mem_addr), .wr_data(mem_wdata),
		.rd_en(mem_re), .rd_addr(mem_addr), .rd_data(mem_rd_data)
	);

	// First ALU stage: simple results and 32x32 partial products.
	assign opb   = is_mem ? mem_rd_data : sv_q;
	assign rot_r = {dv_q, dv_q} >> opb[5:0];
	assign rot_l = {dv_q, dv_q} << opb[5:0];

	always_comb begin
		case (ctl.op)
			OP_IADD_RS:           res_x1 = dv_q + ((sv_q << ctl.shift) + ctl.imm);
			OP_ISUB, OP_ISUB_M:   res_x1 = dv_q - opb;
			OP_INEG:              res_x1 = (~dv_q) + 64'd1;
			OP_IXOR, OP_IXOR_M:   res_x1 = dv_q ^ opb;
			OP_IROR:              res_x1 = rot_r[63:0];
			OP_IROL:              res_x1 = rot_l[127:64];
			OP_ISWAP:             res_x1 = sv_q;
			OP_IADD_M:            res_x1 = dv_q + opb;
			default:              res_x1 = 64'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.x1) begin
			res_s1   <= res_x1;
			pp_ll_s1 <= 64'(dv_q[31:0]) * 64'(opb[31:0]);
			pp_lh_s1 <= 64'(dv_q[31:0]) * 64'(opb[63:32]);
			pp_hl_s1 <= 64'(dv_q[63:32]) * 64'(opb[31:0]);
			pp_hh_s1 <= 64'(dv_q[63:32]) * 64'(opb[63:32]);
			corr_s1  <= (dv_q[63] ? opb : 64'd0) + (opb[63] ? dv_q : 64'd0);
		end
		if (ctl.x2) begin
			res_s2  <= res_s1;
			corr_s2 <= corr_s1;
			prod_s2 <= {pp_hh_s1, 64'd0} + {32'd0, pp_lh_s1, 32'd0}
				+ {32'd0, pp_hl_s1, 32'd0} + {64'd0, pp_ll_s1};
		end
	end

	// Write-back selection, with the signed correction of the high product.
	always_comb begin
		case (ctl.op)
			OP_IMUL, OP_IMUL_M:     res_final = prod_s2[63:0];
			OP_IMULH, OP_IMULH_M:   res_final = prod_s2[127:64];
			OP_ISMULH, OP_ISMULH_M: res_final = prod_s2[127:64] - corr_s2;
			default:                res_final = res_s2;
		endcase
	end
endmodule

// ----- rtl/lvime_checker.sv -----
// Port-level checker for the lane vector integer executor, bound to the top level.
module lvime_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [63:0] rsp_read_data,
	input logic        rsp_was_read
);
	logic [2:0] pend_q;
	logic       req_fire, rsp_fire;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	// Count of requests accepted whose response beat has not gone out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
		end else if (req_fire && !rsp_fire) begin
			pend_q <= pend_q + 3'd1;
		end else if (!req_fire && rsp_fire) begin
			pend_q <= pend_q - 3'd1;
		end
	end

	// A stalled response stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response withdrawn while stalled");

	// Responses to non-read commands carry zero data.
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_fire && !rsp_was_read |-> rsp_read_data == 64'd0)
		else $error("non-read response with nonzero data");

	// No response without an outstanding request.
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 3'd0)
		else $error("response without a request");

	// At most holding, working and response stages are occupied.
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd3)
		else $error("too many requests in flight");
endmodule

bind lane_vector_integer_memory_executor_top lvime_checker u_lvime_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_read_data(rsp.payload.read_data),
	.rsp_was_read(rsp.payload.was_read)
);
